FILE: sv/sdlc_pkg.sv
// ----------------------------------------------------------------------------
// sdlc_pkg: shared definitions for the sphere decoder level cost block
// Fixed-point widths, the Q5.10 generator matrix, queue item and status types
// and the back-end state encoding.
// ----------------------------------------------------------------------------
package sdlc_pkg;

  // Default number of stored cost levels.
  localparam int LEVELS_DEF  = 6;
  // Size of the generator matrix (rows and columns).
  localparam int MAT_DIM     = 6;

  localparam int LEVEL_W     = 3;
  localparam int UK_W        = 16;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = COEF_W + UK_W;
  // The dot product stays well below 2^33 in magnitude.
  localparam int ACC_W       = 36;
  // Fraction bits dropped when Q.18 is rounded to Q.8.
  localparam int RND_SHIFT   = 10;
  localparam int ERR_W       = ACC_W - RND_SHIFT;
  // The rounded error stays below 2^22 in magnitude.
  localparam int MAG_W       = 24;
  localparam int COST_W      = 48;
  localparam int COL_W       = $clog2(MAT_DIM + 1);
  localparam int QUEUE_DEPTH = 2;

  // Lower-triangular generator matrix, Q5.10.
  localparam logic signed [COEF_W-1:0] GEN_Q10 [MAT_DIM][MAT_DIM] = '{
    '{ 16'sd1769,      16'sd0,       16'sd0,      16'sd0,       16'sd0,      16'sd0     },
    '{ -16'sd14112,    16'sd14223,   16'sd0,      16'sd0,       16'sd0,      16'sd0     },
    '{ -16'sd8169,     -16'sd8169,   16'sd16402,  16'sd0,       16'sd0,      16'sd0     },
    '{ 16'sd628,       -16'sd1198,   -16'sd1198,  16'sd1768,    16'sd0,      16'sd0     },
    '{ -16'sd13341,    16'sd13302,   -16'sd82,    -16'sd12839,  16'sd12960,  16'sd0     },
    '{ -16'sd7726,     -16'sd7726,   16'sd15383,  -16'sd7436,   -16'sd7436,  16'sd14941 }
  };

  typedef logic signed [UK_W-1:0] sample_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic                      lvl_ok;
    logic [LEVEL_W-1:0]        level;
    sample_t [MAT_DIM-1:0]     uk;
    sample_t                   target;
  } item_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MAC,
    BK_ROUND,
    BK_SQUARE,
    BK_ACCUM,
    BK_OUT
  } back_state_t;

  // Matrix entry lookup; positions outside the matrix read as zero.
  function automatic logic signed [COEF_W-1:0] gen_coef(input logic [LEVEL_W-1:0] row,
                                                         input logic [COL_W-1:0] col);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (int'(row) < MAT_DIM && int'(col) < MAT_DIM) begin
      c = GEN_Q10[row][col];
    end
    return c;
  endfunction

endpackage

FILE: sv/sphere_decoder_level_cost.sv
// ----------------------------------------------------------------------------
// sphere_decoder_level_cost: partial-distance step of a 6x6 sphere decoder
// One item names a tree level and brings a candidate vector and the target for
// that level; the result is the cumulative cost up to that level.
// ----------------------------------------------------------------------------
// Each item yields exactly one result, in order. An item with a level that has
// a matrix row and a cost slot is taken from the queue, then the cost engine
// steps a single 16x16 multiplier through the six columns of the matrix row,
// rounds, squares and accumulates, and loads the output register once that
// register is free. An item with an out-of-range level goes straight to the
// output register and returns a zero cost. The engine takes no new item until
// it has loaded the last result, so the shared multiplier loop sets the
// sustained rate; the input stage and a two-entry queue take new items while
// the engine works and while a result waits at the output. The cost store is
// cleared by reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sphere_decoder_level_cost
  import sdlc_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // uk_0 [15:0], uk_1, uk_2, uk_3, uk_4, uk_5 [95:80], target_value [111:96]
  input  logic [111:0] in_tdata,
  // level_index [2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // cumulative_cost [47:0]
  output logic [47:0]  out_tdata,
  // cost_saturated [0]
  output logic [0:0]   out_tuser
);

  logic      fr_valid;
  item_t     fr_item;
  q_status_t q_st;
  item_t     q_head;
  logic      q_pop;

  // Input stage.
  sdlc_front #(
    .LEVELS(LEVELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_st     (q_st),
    .fr_valid (fr_valid),
    .fr_item  (fr_item)
  );

  // Queue between the input stage and the cost engine.
  sdlc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fr_valid),
    .push_item(fr_item),
    .pop      (q_pop),
    .q_st     (q_st),
    .head     (q_head)
  );

  // Cost engine and output register.
  sdlc_back #(
    .LEVELS(LEVELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_st      (q_st),
    .head      (q_head),
    .pop       (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // A saturated result always carries the maximum cost.
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == {COST_W{1'b1}})
    else $error("saturated result without maximum cost");

  // An accepted input transfer lands in the holding register.
  a_front_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> fr_valid)
    else $error("accepted transfer lost in the input stage");

  // A full queue stays full until the engine takes an item.
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    q_st.full && !q_pop |=> q_st.full)
    else $error("queue drained without a pop");

endmodule

FILE: sv/sdlc_front.sv
// ----------------------------------------------------------------------------
// sdlc_front: input stage
// Takes input transfers into a holding register, unpacks the fields and marks
// whether the level has a matrix row and a cost slot.
// ----------------------------------------------------------------------------
module sdlc_front
  import sdlc_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // uk_0 [15:0], uk_1, uk_2, uk_3, uk_4, uk_5 [95:80], target_value [111:96]
  input  logic [111:0] in_tdata,
  // level_index [2:0]
  input  logic [2:0]   in_tuser,
  input  q_status_t    q_st,
  output logic         fr_valid,
  output item_t        fr_item
);

  logic  fr_valid_r;
  item_t fr_item_r;
  item_t item_nxt;

  // The holding register frees up when the queue takes its item.
  assign in_tready = !fr_valid_r || !q_st.full;
  assign fr_valid  = fr_valid_r;
  assign fr_item   = fr_item_r;

  // Unpack and classify the incoming transfer.
  always_comb begin
    item_nxt.level  = in_tuser;
    item_nxt.lvl_ok = (int'(in_tuser) < LEVELS) && (int'(in_tuser) < MAT_DIM);
    for (int i = 0; i < MAT_DIM; i++) begin
      item_nxt.uk[i] = in_tdata[i*UK_W +: UK_W];
    end
    item_nxt.target = in_tdata[MAT_DIM*UK_W +: UK_W];
  end

  // Holding register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (in_tready) begin
      fr_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      fr_item_r <= item_nxt;
    end
  end

endmodule

FILE: sv/sdlc_queue.sv
// ----------------------------------------------------------------------------
// sdlc_queue: short item queue
// Decouples the input stage from the cost engine so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
module sdlc_queue
  import sdlc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output q_status_t q_st,
  output item_t     head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign q_st.valid = (count_r != '0);
  assign q_st.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !q_st.full;
  assign do_pop     = pop && q_st.valid;

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: sv/sdlc_back.sv
// ----------------------------------------------------------------------------
// sdlc_back: cost engine
// Steps one multiplier through the matrix row, rounds and squares the error,
// adds the previous level's cost with saturation and holds the result.
// ----------------------------------------------------------------------------
module sdlc_back
  import sdlc_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  q_status_t   q_st,
  input  item_t       head,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cumulative_cost [47:0]
  output logic [47:0] out_tdata,
  // cost_saturated [0]
  output logic [0:0]  out_tuser
);

  localparam int IDX_W = $clog2(LEVELS);

  back_state_t              state_r;
  back_state_t              state_nxt;
  logic [COL_W-1:0]         cnt_r;
  item_t                    item_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [MAG_W-1:0]         mag_r;
  logic [COST_W-1:0]        prev_r;
  logic [COST_W-1:0]        sq_r;
  logic [COST_W-1:0]        total_r;
  logic                     sat_r;
  logic [COST_W-1:0]        cost_r [LEVELS];
  logic                     out_valid_r;
  logic [COST_W-1:0]        out_cost_r;
  logic                     out_sat_r;
  logic                     out_load;

  logic signed [UK_W-1:0]   uk_sel;
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [ACC_W-1:0]  acc_init;
  logic signed [ACC_W-1:0]  biased;
  logic signed [ERR_W-1:0]  err8;
  logic [ERR_W-1:0]         err_abs;
  logic [COST_W:0]          sum;
  logic [IDX_W-1:0]         cur_idx;
  logic [IDX_W-1:0]         prev_idx;

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_cost_r;
  assign out_tuser[0] = out_sat_r;

  // Operand selection for the shared multiplier.
  always_comb begin
    uk_sel = '0;
    if (int'(cnt_r) < MAT_DIM) begin
      uk_sel = item_r.uk[cnt_r];
    end
    coef_sel = gen_coef(item_r.level, cnt_r);
  end

  // Start value of the accumulator: minus the target aligned to Q.18.
  assign acc_init = -{{(ACC_W - UK_W - RND_SHIFT){head.target[UK_W-1]}},
                      head.target, {RND_SHIFT{1'b0}}};

  // Round Q.18 to Q.8 with halves going toward plus infinity.
  assign biased  = acc_r + ACC_W'(1 << (RND_SHIFT - 1));
  assign err8    = biased[ACC_W-1:RND_SHIFT];
  assign err_abs = err8[ERR_W-1] ? ERR_W'(-err8) : ERR_W'(err8);

  // Saturating sum with the previous level's cost.
  assign sum      = {1'b0, prev_r} + {1'b0, sq_r};
  assign cur_idx  = IDX_W'(item_r.level);
  assign prev_idx = IDX_W'(item_r.level - 1'b1);

  // Sequencer: next state, queue pop and output load.
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_st.valid) begin
          pop       = 1'b1;
          state_nxt = head.lvl_ok ? BK_MAC : BK_OUT;
        end
      end
      BK_MAC: begin
        if (cnt_r == COL_W'(MAT_DIM)) begin
          state_nxt = BK_ROUND;
        end
      end
      BK_ROUND:  state_nxt = BK_SQUARE;
      BK_SQUARE: state_nxt = BK_ACCUM;
      BK_ACCUM:  state_nxt = BK_OUT;
      BK_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath: one product per cycle, added to the accumulator in the next cycle; then round, square and saturating sum.
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (pop) begin
          item_r  <= head;
          cnt_r   <= '0;
          acc_r   <= acc_init;
          total_r <= '0;
          sat_r   <= 1'b0;
        end
      end
      BK_MAC: begin
        if (int'(cnt_r) < MAT_DIM) begin
          prod_r <= coef_sel * uk_sel;
        end
        if (cnt_r != '0) begin
          acc_r <= acc_r + ACC_W'(prod_r);
        end
        cnt_r <= cnt_r + 1'b1;
      end
      BK_ROUND: begin
        mag_r  <= err_abs[MAG_W-1:0];
        prev_r <= (item_r.level == '0) ? '0 : cost_r[prev_idx];
      end
      BK_SQUARE: begin
        sq_r <= mag_r * mag_r;
      end
      BK_ACCUM: begin
        total_r <= sum[COST_W] ? {COST_W{1'b1}} : sum[COST_W-1:0];
        sat_r   <= sum[COST_W];
      end
      default: begin
      end
    endcase
  end

  // Cost store, one slot per level, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        cost_r[i] <= '0;
      end
    end else if (state_r == BK_ACCUM) begin
      cost_r[cur_idx] <= sum[COST_W] ? {COST_W{1'b1}} : sum[COST_W-1:0];
    end
  end

  // Output register: holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cost_r <= total_r;
      out_sat_r  <= sat_r;
    end
  end

endmodule

FILE: sim/sphere_decoder_level_cost_test.sv
// ----------------------------------------------------------------------------
// sphere_decoder_level_cost_test: self-checking bench for the level cost block
// Drives tree-level items into the input stream and checks every cumulative
// cost against an independent fixed-point predictor of the partial distance.
// A short directed set covers extremes, rounding halves and out-of-range
// levels. Mostly depth-first level runs with random content follow, under
// random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module sphere_decoder_level_cost_test;
  import sdlc_pkg::*;

  localparam int LEVEL_COUNT = 6;
  localparam int RANDOM_ITEMS = 1500;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AT = 500;
  localparam longint unsigned COST_LIMIT = 64'h0000_FFFF_FFFF_FFFF;

  typedef struct {
    logic [47:0] cost;
    logic        sat;
  } cost_result_t;

  // Predicts the cumulative cost of each item and holds the costs still owed.
  class level_cost_checker;
    int           coef [6][6];
    bit [47:0]    stored_cost [6];
    cost_result_t awaited [$];
    int           errors;

    function new();
      coef = '{
        '{  1769,      0,     0,      0,     0,     0 },
        '{ -14112, 14223,     0,      0,     0,     0 },
        '{ -8169,  -8169, 16402,      0,     0,     0 },
        '{   628,  -1198, -1198,   1768,     0,     0 },
        '{ -13341, 13302,   -82, -12839, 12960,     0 },
        '{ -7726,  -7726, 15383,  -7436, -7436, 14941 }
      };
      foreach (stored_cost[i]) stored_cost[i] = '0;
      errors = 0;
    endfunction

    // Works out the cost of one accepted item and queues it.
    function void take_item(logic [2:0] level, logic [111:0] data);
      longint            acc;
      longint            err;
      longint unsigned   mag;
      longint unsigned   total;
      cost_result_t      r;
      r.cost = '0;
      r.sat  = 1'b0;
      if (level < LEVEL_COUNT) begin
        acc = 0;
        for (int i = 0; i < 6; i++) begin
          acc += longint'(coef[level][i]) * longint'($signed(data[16*i +: 16]));
        end
        acc -= longint'($signed(data[96 +: 16])) * 1024;
        // Q.18 to Q.8, halves go toward plus infinity.
        err = (acc + 512) >>> 10;
        mag = (err < 0) ? -err : err;
        total = mag * mag;
        if (level != 0) begin
          total += stored_cost[level - 1];
        end
        if (total > COST_LIMIT) begin
          total = COST_LIMIT;
          r.sat = 1'b1;
        end
        stored_cost[level] = total[47:0];
        r.cost = total[47:0];
      end
      awaited.push_back(r);
    endfunction

    // Compares one result transfer with the oldest cost still owed.
    function void check_cost(logic [47:0] cost, logic sat);
      cost_result_t e;
      if (awaited.size() == 0) begin
        $error("result with nothing owed: cumulative_cost %0d", cost);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (cost !== e.cost) begin
        $error("cumulative_cost: expected %0d, got %0d", e.cost, cost);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("cost_saturated: expected %0b, got %0b", e.sat, sat);
        errors++;
      end
    endfunction

    function int owed();
      return awaited.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;
  logic [0:0]   out_tuser;

  level_cost_checker costs = new();
  bit                send_burst = 1'b0;
  int                idle_cycles = 0;

  sphere_decoder_level_cost #(
    .LEVELS(LEVEL_COUNT)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Clock generation.
  initial begin
    forever #1 clk = ~clk;
  end

  // Packs a candidate vector and a target into the input word.
  function automatic logic [111:0] pack_item(logic [15:0] u0, logic [15:0] u1,
                                             logic [15:0] u2, logic [15:0] u3,
                                             logic [15:0] u4, logic [15:0] u5,
                                             logic [15:0] target);
    return {target, u5, u4, u3, u2, u1, u0};
  endfunction

  // Draws a sample: extremes, small values around zero, or anything at all.
  function automatic logic [15:0] draw_sample();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = 16'h0000;
      3, 4, 5: v = 16'($urandom_range(0, 2047) - 1024);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // Offers one item after a random gap and waits for its transfer.
  task automatic send_item(input logic [2:0] level, input logic [111:0] data);
    int gap;
    if ($urandom_range(0, 63) == 0) begin
      send_burst = ~send_burst;
    end
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= level;
    do @(posedge clk); while (!in_tready);
    costs.take_item(level, data);
  endtask

  task automatic send_random(input logic [2:0] level);
    send_item(level, pack_item(draw_sample(), draw_sample(), draw_sample(),
                               draw_sample(), draw_sample(), draw_sample(),
                               draw_sample()));
  endtask

  // Result sink: random stalls, stall-free stretches and one long hold-off.
  initial begin : result_sink
    int  stall;
    int  results_seen;
    bit  held;
    results_seen = 0;
    held = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (results_seen == HOLD_OFF_AT && !held) begin
        stall = HOLD_OFF_CYCLES;
        held = 1'b1;
      end else if ((results_seen % 128) < 32) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 17);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      costs.check_cost(out_tdata, out_tuser[0]);
      results_seen++;
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int          sent;
    int          depth;
    int          pick;
    logic [2:0]  lv;
    sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Level 3 first: its predecessor slot still holds the reset value.
    send_item(3'd3, pack_item(16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000,
                              16'd1000, 16'd0));
    // Full runs at both extremes of the samples.
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      send_item(3'(i), pack_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                 16'h7FFF, 16'h8000));
    end
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      send_item(3'(i), pack_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                 16'h8000, 16'h7FFF));
    end
    // Row 4 with signs matched to its coefficients: largest error of that row.
    send_item(3'd4, pack_item(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                              16'h0000, 16'h8000));
    // Levels beyond the matrix return zero and leave the stored costs alone.
    send_item(3'd6, pack_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                              16'h7FFF, 16'h7FFF));
    send_item(3'd7, pack_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'h0000));
    // Errors of exactly one half, positive and negative.
    send_item(3'd0, pack_item(16'd512, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    send_item(3'd0, pack_item(16'hFE00, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    // All-zero items give zero cost.
    send_item(3'd0, '0);
    send_item(3'd1, '0);

    // Mostly depth-first runs from the root, plus single levels and noise.
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        depth = $urandom_range(0, LEVEL_COUNT - 1);
        for (int i = 0; i <= depth; i++) begin
          send_random(3'(i));
          sent++;
        end
      end else if (pick < 85) begin
        lv = 3'($urandom_range(0, LEVEL_COUNT - 1));
        send_random(lv);
        sent++;
      end else begin
        lv = 3'($urandom_range(0, 7));
        send_random(lv);
        sent++;
      end
    end
    in_tvalid <= 1'b0;

    while (costs.owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (costs.owed() != 0) begin
      $error("%0d costs never arrived", costs.owed());
      costs.errors++;
    end
    if (costs.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
